@@ rtl/core/three_rotor_cipher_machine_assert.svh @@
// Assertion macros for the three-rotor cipher machine.
// Included by the top level; no other dependencies.
`ifndef THREE_ROTOR_CIPHER_MACHINE_ASSERT_SVH
`define THREE_ROTOR_CIPHER_MACHINE_ASSERT_SVH

// same-cycle implication
`define RCM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RCM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/rcm_pkg.sv @@
// Shared types, tables and helpers of the three-rotor cipher machine.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package rcm_pkg;

   localparam int LetterWidth = 5;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth = 5;

   typedef logic [LetterWidth-1:0] letter_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_ROTOR_ORDER  = 2'd0,
      CSR_FAST_START   = 2'd1,
      CSR_MIDDLE_START = 2'd2,
      CSR_SLOW_START   = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      WIRE_I   = 2'd0,
      WIRE_II  = 2'd1,
      WIRE_III = 2'd2
   } wire_sel_type;

   typedef enum logic [2:0] {
      ORDER_123 = 3'd0,
      ORDER_213 = 3'd1,
      ORDER_231 = 3'd2,
      ORDER_312 = 3'd3,
      ORDER_321 = 3'd4,
      ORDER_132 = 3'd5
   } order_code_type;

   typedef struct packed {
      wire_sel_type fast;
      wire_sel_type middle;
      wire_sel_type slow;
   } order_type;

   typedef struct packed {
      letter_type fast;
      letter_type middle;
      letter_type slow;
   } pos_type;

   // one queued item, also the payload of the first two back-end stages
   typedef struct packed {
      letter_type letter;
      pos_type    pos;
      order_type  ord;
   } job_type;

   localparam letter_type PLUG [32] = '{
      5'd1, 5'd0, 5'd3, 5'd2, 5'd5, 5'd4, 5'd6, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19,
      5'd13, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd20, 5'd25, 5'd22, 5'd23, 5'd24,
      5'd21, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0};

   localparam letter_type FWD_I [32] = '{
      5'd21, 5'd4, 5'd19, 5'd0, 5'd1, 5'd25, 5'd10, 5'd23, 5'd20, 5'd8, 5'd16, 5'd18, 5'd5,
      5'd9, 5'd3, 5'd11, 5'd22, 5'd7, 5'd14, 5'd2, 5'd13, 5'd12, 5'd24, 5'd17, 5'd6,
      5'd15, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0};

   localparam letter_type FWD_II [32] = '{
      5'd10, 5'd2, 5'd20, 5'd12, 5'd22, 5'd8, 5'd6, 5'd15, 5'd18, 5'd9, 5'd14, 5'd13, 5'd7,
      5'd5, 5'd19, 5'd23, 5'd11, 5'd4, 5'd24, 5'd1, 5'd21, 5'd17, 5'd16, 5'd0, 5'd25,
      5'd3, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0};

   localparam letter_type FWD_III [32] = '{
      5'd10, 5'd7, 5'd18, 5'd2, 5'd23, 5'd1, 5'd11, 5'd13, 5'd25, 5'd4, 5'd8, 5'd24, 5'd22,
      5'd5, 5'd14, 5'd20, 5'd16, 5'd9, 5'd21, 5'd17, 5'd19, 5'd15, 5'd0, 5'd6, 5'd3,
      5'd12, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0};

   localparam letter_type INV_I [32] = '{
      5'd3, 5'd4, 5'd19, 5'd14, 5'd1, 5'd12, 5'd24, 5'd17, 5'd9, 5'd13, 5'd6, 5'd15, 5'd21,
      5'd20, 5'd18, 5'd25, 5'd10, 5'd23, 5'd11, 5'd2, 5'd8, 5'd0, 5'd16, 5'd7, 5'd22,
      5'd5, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0};

   localparam letter_type INV_II [32] = '{
      5'd23, 5'd19, 5'd1, 5'd25, 5'd17, 5'd13, 5'd6, 5'd12, 5'd5, 5'd9, 5'd0, 5'd16, 5'd3,
      5'd11, 5'd10, 5'd7, 5'd22, 5'd21, 5'd8, 5'd14, 5'd2, 5'd20, 5'd4, 5'd15, 5'd18,
      5'd24, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0};

   localparam letter_type INV_III [32] = '{
      5'd22, 5'd5, 5'd3, 5'd24, 5'd9, 5'd13, 5'd23, 5'd1, 5'd10, 5'd17, 5'd0, 5'd6, 5'd25,
      5'd7, 5'd14, 5'd21, 5'd16, 5'd19, 5'd2, 5'd20, 5'd15, 5'd18, 5'd12, 5'd4, 5'd11,
      5'd8, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0};

   localparam letter_type LAST_LETTER = 5'd25;
   localparam letter_type REFLECT_SHIFT = 5'd13;

   function automatic letter_type fold26(input letter_type v);
      return (v >= 5'd26) ? v - 5'd26 : v;
   endfunction

   function automatic letter_type add26(input letter_type a, input letter_type b);
      logic [LetterWidth:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s >= 6'd26) ? LetterWidth'(s - 6'd26) : LetterWidth'(s);
   endfunction

   function automatic letter_type sub26(input letter_type a, input letter_type b);
      logic [LetterWidth:0] s;
      s = {1'b0, a} + 6'd26 - {1'b0, b};
      return (a >= b) ? a - b : LetterWidth'(s);
   endfunction

   function automatic letter_type rotor_fwd(input wire_sel_type w, input letter_type x,
                                            input letter_type p);
      letter_type idx;
      letter_type r;
      idx = add26(x, p);
      unique case (w)
         WIRE_II:  r = FWD_II[idx];
         WIRE_III: r = FWD_III[idx];
         default:  r = FWD_I[idx];
      endcase
      return r;
   endfunction

   function automatic letter_type rotor_back(input wire_sel_type w, input letter_type x,
                                             input letter_type p);
      letter_type r;
      unique case (w)
         WIRE_II:  r = INV_II[x];
         WIRE_III: r = INV_III[x];
         default:  r = INV_I[x];
      endcase
      return sub26(r, p);
   endfunction

   // unused codes fall back to order 1,2,3
   function automatic order_type decode_order(input logic [2:0] code);
      order_type o;
      unique case (code)
         ORDER_213: o = '{fast: WIRE_II,  middle: WIRE_I,   slow: WIRE_III};
         ORDER_231: o = '{fast: WIRE_II,  middle: WIRE_III, slow: WIRE_I};
         ORDER_312: o = '{fast: WIRE_III, middle: WIRE_I,   slow: WIRE_II};
         ORDER_321: o = '{fast: WIRE_III, middle: WIRE_II,  slow: WIRE_I};
         ORDER_132: o = '{fast: WIRE_I,   middle: WIRE_III, slow: WIRE_II};
         default:   o = '{fast: WIRE_I,   middle: WIRE_II,  slow: WIRE_III};
      endcase
      return o;
   endfunction

   function automatic pos_type advance(input pos_type p);
      pos_type n;
      n = p;
      if (p.fast == LAST_LETTER) begin
         n.fast = '0;
         if (p.middle == LAST_LETTER) begin
            n.middle = '0;
            n.slow = (p.slow == LAST_LETTER) ? '0 : p.slow + 5'd1;
         end else begin
            n.middle = p.middle + 5'd1;
         end
      end else begin
         n.fast = p.fast + 5'd1;
      end
      return n;
   endfunction

endpackage

@@ rtl/core/rcm_front.sv @@
// Front end: configuration registers, rotor odometer and order decode.
// Depends on rcm_pkg; feeds rcm_queue.
`timescale 1ns / 1ps

module rcm_front
   import rcm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  letter_type               in_letter,
   input  logic                     in_restart,
   output logic                     job_valid,
   input  logic                     job_ready,
   output job_type                  job
);

   logic [2:0] order_ff;
   letter_type fast_start_ff;
   letter_type middle_start_ff;
   letter_type slow_start_ff;
   pos_type    pos_ff;
   pos_type    pos_in;
   pos_type    pos_cur;
   logic       accept;

   assign in_ready  = job_ready;
   assign job_valid = in_valid;
   assign accept    = in_valid && job_ready;

   always_comb begin
      if (in_restart) begin
         pos_cur = '{fast: fold26(fast_start_ff), middle: fold26(middle_start_ff),
                     slow: fold26(slow_start_ff)};
      end else begin
         pos_cur = pos_ff;
      end
      pos_in     = accept ? advance(pos_cur) : pos_ff;
      job.letter = fold26(in_letter);
      job.pos    = pos_cur;
      job.ord    = decode_order(order_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff        <= '0;
         fast_start_ff   <= '0;
         middle_start_ff <= '0;
         slow_start_ff   <= '0;
         pos_ff          <= '0;
      end else begin
         pos_ff <= pos_in;
         if (csr_we) begin
            case (csr_index)
               CSR_ROTOR_ORDER:  order_ff        <= csr_wdata[2:0];
               CSR_FAST_START:   fast_start_ff   <= csr_wdata;
               CSR_MIDDLE_START: middle_start_ff <= csr_wdata;
               CSR_SLOW_START:   slow_start_ff   <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

endmodule

@@ rtl/core/rcm_queue.sv @@
// Short item queue between front and back end.
// Depends on rcm_pkg for the item type.
`timescale 1ns / 1ps

module rcm_queue
   import rcm_pkg::*;
#(
   parameter int Depth = 2
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  job_type in_job,
   output logic    out_valid,
   input  logic    out_ready,
   output job_type out_job,
   output logic    full
);

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);

   job_type                 mem [Depth];
   logic [PtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]   count_ff, count_in;
   logic                    push, pop;

   assign full      = (count_ff == CountWidth'(Depth));
   assign in_ready  = !full;
   assign out_valid = (count_ff != '0);
   assign out_job   = mem[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CountWidth'(push) - CountWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= in_job;
      end
   end

endmodule

@@ rtl/core/rcm_back.sv @@
// Back end: three-stage cipher pipeline with stall and output register.
// Depends on rcm_pkg for the tables and rotor helpers.
`timescale 1ns / 1ps

module rcm_back
   import rcm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  job_type    in_job,
   output logic       out_valid,
   input  logic       out_ready,
   output letter_type out_letter
);

   logic       a_valid_ff, a_valid_in;
   logic       b_valid_ff, b_valid_in;
   logic       o_valid_ff, o_valid_in;
   job_type    a_ff, a_in;
   job_type    b_ff, b_in;
   letter_type o_ff, o_in;
   logic       a_ready, b_ready, o_ready;

   assign o_ready  = !o_valid_ff || out_ready;
   assign b_ready  = !b_valid_ff || o_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   // plugboard, fast and middle rotors forward
   always_comb begin
      a_in        = in_job;
      a_in.letter = rotor_fwd(in_job.ord.middle,
                              rotor_fwd(in_job.ord.fast, PLUG[in_job.letter], in_job.pos.fast),
                              in_job.pos.middle);
   end

   // slow rotor forward, reflector, slow rotor back
   always_comb begin
      b_in        = a_ff;
      b_in.letter = rotor_back(a_ff.ord.slow,
                               add26(rotor_fwd(a_ff.ord.slow, a_ff.letter, a_ff.pos.slow),
                                     REFLECT_SHIFT),
                               a_ff.pos.slow);
   end

   // middle and fast rotors back, plugboard
   always_comb begin
      o_in = PLUG[rotor_back(b_ff.ord.fast,
                             rotor_back(b_ff.ord.middle, b_ff.letter, b_ff.pos.middle),
                             b_ff.pos.fast)];
   end

   always_comb begin
      a_valid_in = a_ready ? in_valid : a_valid_ff;
      b_valid_in = b_ready ? a_valid_ff : b_valid_ff;
      o_valid_in = o_ready ? b_valid_ff : o_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_ff <= a_in;
      end
      if (b_ready) begin
         b_ff <= b_in;
      end
      if (o_ready) begin
         o_ff <= o_in;
      end
   end

   assign out_valid  = o_valid_ff;
   assign out_letter = o_ff;

endmodule

@@ rtl/core/three_rotor_cipher_machine.sv @@
// Three-rotor cipher machine: enciphers one letter (0..25) per item and
// returns one enciphered letter per item, in order. Sustained rate is one
// item per clock while results are not stalled; each item passes through
// the item queue, the first two cipher stages and the output register,
// which is the third stage. The rotor odometer in the front end advances
// once per accepted item; a restart flag first reloads the positions from
// the start registers. Order writes take effect at the next accepted item,
// start writes at the next restart. Depends on rcm_pkg and the assert header.
`timescale 1ns / 1ps

`include "three_rotor_cipher_machine_assert.svh"

module three_rotor_cipher_machine
   import rcm_pkg::*;
#(
   parameter int QueueDepth = 2
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,   // [4:0] letter_in
   input  logic [0:0]               req_tuser,   // [0] restart
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [7:0]               rsp_tdata,   // [4:0] letter_out
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   logic       front_valid, front_ready;
   job_type    front_job;
   logic       q_valid, q_full;
   job_type    q_job;
   logic       back_ready;
   letter_type out_letter;

   rcm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_letter  (req_tdata[LetterWidth-1:0]),
      .in_restart (req_tuser[0]),
      .job_valid  (front_valid),
      .job_ready  (front_ready),
      .job        (front_job)
   );

   rcm_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_job    (front_job),
      .out_valid (q_valid),
      .out_ready (back_ready),
      .out_job   (q_job),
      .full      (q_full)
   );

   rcm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (q_valid),
      .in_ready   (back_ready),
      .in_job     (q_job),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_letter (out_letter)
   );

   assign rsp_tdata = {3'b000, out_letter};

   `RCM_ASSERT_IMP(a_letter_range, clock, reset, rsp_tvalid, rsp_tdata <= 8'd25,
      "result letter out of range")
   `RCM_ASSERT_IMP(a_full_blocks, clock, reset, q_full, !req_tready,
      "item accepted into a full queue")
   `RCM_ASSERT_IMP(a_stall_source, clock, reset, !back_ready, rsp_tvalid && !rsp_tready,
      "back end stalled without a held result")

endmodule

@@ test/three_rotor_cipher_machine_checker.sv @@
// Checker for the three-rotor cipher machine: watches the item, result and
// register-write ports, predicts each enciphered letter and compares in order.
// Depends on rcm_pkg for the letter type and the register and order codes.
`timescale 1ns / 1ps

module three_rotor_cipher_machine_checker
   import rcm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [7:0]               req_tdata,   // [4:0] letter_in
   input  logic [0:0]               req_tuser,   // [0] restart
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [7:0]               rsp_tdata,   // [4:0] letter_out
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata,
   output int                       mismatch_count,
   output int                       pending_items
);

   localparam int PLUGBOARD [26] = '{
      1, 0, 3, 2, 5, 4, 6, 14, 15, 16, 17, 18, 19,
      13, 7, 8, 9, 10, 11, 12, 20, 25, 22, 23, 24, 21};

   localparam int ROTOR_WIRING [3][26] = '{
      '{21, 4, 19, 0, 1, 25, 10, 23, 20, 8, 16, 18, 5,
        9, 3, 11, 22, 7, 14, 2, 13, 12, 24, 17, 6, 15},
      '{10, 2, 20, 12, 22, 8, 6, 15, 18, 9, 14, 13, 7,
        5, 19, 23, 11, 4, 24, 1, 21, 17, 16, 0, 25, 3},
      '{10, 7, 18, 2, 23, 1, 11, 13, 25, 4, 8, 24, 22,
        5, 14, 20, 16, 9, 21, 17, 19, 15, 0, 6, 3, 12}};

   logic [2:0] order_reg;
   logic [4:0] fast_start_reg;
   logic [4:0] middle_start_reg;
   logic [4:0] slow_start_reg;
   int         fast_pos;
   int         middle_pos;
   int         slow_pos;
   int         error_total;
   letter_type cipher_q [$];

   function automatic int reduce_letter(input logic [4:0] v);
      return (v >= 5'd26) ? int'(v) - 26 : int'(v);
   endfunction

   // wiring index in the fast, middle and slow slot
   function automatic void slot_wirings(input logic [2:0] code, output int fast_w,
                                        output int middle_w, output int slow_w);
      case (code)
         ORDER_213: begin fast_w = 1; middle_w = 0; slow_w = 2; end
         ORDER_231: begin fast_w = 1; middle_w = 2; slow_w = 0; end
         ORDER_312: begin fast_w = 2; middle_w = 0; slow_w = 1; end
         ORDER_321: begin fast_w = 2; middle_w = 1; slow_w = 0; end
         ORDER_132: begin fast_w = 0; middle_w = 2; slow_w = 1; end
         default: begin fast_w = 0; middle_w = 1; slow_w = 2; end
      endcase
   endfunction

   function automatic int rotor_forward(input int w, input int x, input int p);
      return ROTOR_WIRING[w][(x + p) % 26];
   endfunction

   function automatic int rotor_reverse(input int w, input int x, input int p);
      int hit;
      hit = 0;
      for (int i = 0; i < 26; i++)
         if (ROTOR_WIRING[w][i] == x) hit = i;
      return (hit + 26 - p) % 26;
   endfunction

   function automatic letter_type encipher(input int letter, input logic [2:0] code,
                                           input int fp, input int mp, input int sp);
      int fw;
      int mw;
      int sw;
      int x;
      slot_wirings(code, fw, mw, sw);
      x = PLUGBOARD[letter];
      x = rotor_forward(fw, x, fp);
      x = rotor_forward(mw, x, mp);
      x = rotor_forward(sw, x, sp);
      x = (x + 13) % 26;
      x = rotor_reverse(sw, x, sp);
      x = rotor_reverse(mw, x, mp);
      x = rotor_reverse(fw, x, fp);
      x = PLUGBOARD[x];
      return letter_type'(x);
   endfunction

   always @(posedge clock) begin
      letter_type predicted;
      if (reset) begin
         order_reg = ORDER_123;
         fast_start_reg = '0;
         middle_start_reg = '0;
         slow_start_reg = '0;
         fast_pos = 0;
         middle_pos = 0;
         slow_pos = 0;
         error_total = 0;
         cipher_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ROTOR_ORDER:  order_reg = csr_wdata[2:0];
               CSR_FAST_START:   fast_start_reg = csr_wdata;
               CSR_MIDDLE_START: middle_start_reg = csr_wdata;
               CSR_SLOW_START:   slow_start_reg = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (cipher_q.size() == 0) begin
               error_total++;
               if (error_total <= 10)
                  $display("%0t: unexpected letter_out %0d, nothing predicted",
                           $realtime, rsp_tdata);
            end else begin
               predicted = cipher_q.pop_front();
               if (rsp_tdata !== {3'b000, predicted}) begin
                  error_total++;
                  if (error_total <= 10)
                     $display("%0t: letter_out error: got %0d, predicted %0d",
                              $realtime, rsp_tdata, predicted);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser[0]) begin
               fast_pos = reduce_letter(fast_start_reg);
               middle_pos = reduce_letter(middle_start_reg);
               slow_pos = reduce_letter(slow_start_reg);
            end
            cipher_q.insert(cipher_q.size(),
                            encipher(reduce_letter(req_tdata[4:0]), order_reg,
                                     fast_pos, middle_pos, slow_pos));
            fast_pos++;
            if (fast_pos == 26) begin
               fast_pos = 0;
               middle_pos++;
               if (middle_pos == 26) begin
                  middle_pos = 0;
                  slow_pos = (slow_pos + 1) % 26;
               end
            end
         end
      end
      mismatch_count <= error_total;
      pending_items <= cipher_q.size();
   end

endmodule

@@ test/three_rotor_cipher_machine_tb.sv @@
// Testbench top for the three-rotor cipher machine: drives letters and register
// writes with random bursts and stalls, and reports the checker's verdict.
// Depends on rcm_pkg, the block and three_rotor_cipher_machine_checker.
`timescale 1ns / 1ps

module three_rotor_cipher_machine_tb;
   import rcm_pkg::*;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [7:0]               req_tdata = '0;   // [4:0] letter_in
   logic [0:0]               req_tuser = '0;   // [0] restart
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [7:0]               rsp_tdata;        // [4:0] letter_out
   logic                     csr_we = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_wdata = '0;
   int                       mismatch_count;
   int                       pending_items;

   int burst_left = 0;
   bit gaps_on = 1'b1;
   int stall_left = 0;
   int stall_mode = 0;

   three_rotor_cipher_machine uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   three_rotor_cipher_machine_checker cipher_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .mismatch_count(mismatch_count), .pending_items(pending_items)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result-side stalls: full rate, light, heavy and sparse stretches
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(50, 300);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= ($urandom_range(0, 1) != 0);
         default: rsp_tready <= (stall_left % 8 == 0);
      endcase
   end

   task automatic send_letter(input logic [4:0] letter, input bit restart);
      if (gaps_on && burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(1, 20);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, letter};
      req_tuser <= restart;
      do @(posedge clock); while (!req_tready);
      if (burst_left > 0) burst_left--;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_items != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [4:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // register writes only once every item in flight has come out
   task automatic apply_settings(input logic [3:0] mask, input logic [2:0] order,
                                 input logic [4:0] fs, input logic [4:0] ms,
                                 input logic [4:0] ss);
      wait_idle();
      if (mask[0]) write_reg(CSR_ROTOR_ORDER, {2'b00, order});
      if (mask[1]) write_reg(CSR_FAST_START, fs);
      if (mask[2]) write_reg(CSR_MIDDLE_START, ms);
      if (mask[3]) write_reg(CSR_SLOW_START, ss);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [4:0] random_start();
      case ($urandom_range(0, 5))
         0, 1: return 5'($urandom_range(22, 25));
         2: return 5'($urandom_range(26, 31));
         default: return 5'($urandom_range(0, 25));
      endcase
   endfunction

   initial begin
      logic [4:0] letter;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings, letter extremes and out-of-range letters
      send_letter(5'd0, 1'b1);
      send_letter(5'd25, 1'b0);
      send_letter(5'd26, 1'b0);
      send_letter(5'd31, 1'b0);
      send_letter(5'd13, 1'b0);
      wait_idle();

      // all rotors at the last letter: full carry through the odometer
      apply_settings(4'b1111, ORDER_132, 5'd25, 5'd25, 5'd25);
      send_letter(5'd1, 1'b1);
      send_letter(5'd2, 1'b0);
      send_letter(5'd3, 1'b0);
      wait_idle();

      // unused order code, out-of-range starts
      apply_settings(4'b1111, 3'd7, 5'd31, 5'd26, 5'd30);
      send_letter(5'd4, 1'b1);
      send_letter(5'd5, 1'b0);
      apply_settings(4'b0001, 3'd6, 5'd0, 5'd0, 5'd0);
      send_letter(5'd6, 1'b1);
      wait_idle();

      // start written without restart keeps the positions
      apply_settings(4'b1111, ORDER_213, 5'd5, 5'd24, 5'd0);
      send_letter(5'd7, 1'b0);
      send_letter(5'd8, 1'b1);
      wait_idle();
      apply_settings(4'b0001, ORDER_231, 5'd0, 5'd0, 5'd0);
      send_letter(5'd9, 1'b0);
      apply_settings(4'b0001, ORDER_312, 5'd0, 5'd0, 5'd0);
      send_letter(5'd10, 1'b0);
      apply_settings(4'b0001, ORDER_321, 5'd0, 5'd0, 5'd0);
      send_letter(5'd11, 1'b0);
      apply_settings(4'b0001, ORDER_123, 5'd0, 5'd0, 5'd0);
      send_letter(5'd21, 1'b1);
      wait_idle();

      for (int phase = 0; phase < 12; phase++) begin
         apply_settings((phase == 0) ? 4'b1111 : 4'($urandom_range(1, 15)),
                        3'($urandom_range(0, 7)), random_start(), random_start(),
                        random_start());
         gaps_on = ($urandom_range(0, 3) != 0);
         burst_left = 0;
         for (int n = 0; n < 150; n++) begin
            letter = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(26, 31))
                                                 : 5'($urandom_range(0, 25));
            send_letter(letter, (n == 0) ? ($urandom_range(0, 3) != 0)
                                         : ($urandom_range(0, 39) == 0));
         end
         wait_idle();
      end

      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && pending_items == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
